### rtl/core/assert_macros.svh
// assertion macros used by the note sequencer rtl
// expects aclk and aresetn in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("note sequencer assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("note sequencer assertion failed");

`endif

### rtl/core/nspt_pkg.sv
// note sequencer package: beat types, codes, reset values, tone decode helpers
// no dependencies
package nspt_pkg;

    localparam int SCORE_DEPTH_DEF = 256;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 9;

    localparam logic [7:0] TIME_UNIT_RST = 8'd83;
    localparam logic [8:0] SCORE_LEN_RST = 9'd1;

    typedef enum logic [2:0] {
        KIND_TICK = 3'd0,
        KIND_STEP = 3'd1,
        KIND_PLAY = 3'd2,
        KIND_STOP = 3'd3,
        KIND_LOAD = 3'd4
    } nspt_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_UNIT    = 1'b0,
        CFG_SCORE_LENGTH = 1'b1
    } nspt_cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  load_index;
        logic [15:0] load_word;
    } nspt_in_t;

    typedef struct packed {
        logic [12:0] pwm_period;
        logic [10:0] pwm_compare;
        logic        pwm_enable;
        logic [7:0]  score_position;
        logic        playing;
    } nspt_out_t;

    typedef struct packed {
        logic        en;
        logic [7:0]  index;
        logic [15:0] word;
    } nspt_mem_wr_t;

    function automatic logic [15:0] tone_base(input logic [3:0] note);
        logic [15:0] val;
        case (note)
            4'd0:    val = 16'd37079;
            4'd1:    val = 16'd34998;
            4'd2:    val = 16'd33033;
            4'd3:    val = 16'd31179;
            4'd4:    val = 16'd29429;
            4'd5:    val = 16'd27778;
            4'd6:    val = 16'd26219;
            4'd7:    val = 16'd24747;
            4'd8:    val = 16'd23358;
            4'd9:    val = 16'd22047;
            4'd10:   val = 16'd20810;
            4'd11:   val = 16'd19642;
            default: val = 16'd0;
        endcase
        return val;
    endfunction

    // semitone to pwm period: table entry shifted by octave plus 3
    function automatic logic [12:0] period_of(input logic [5:0] semi);
        logic [2:0]  oct;
        logic [5:0]  off;
        logic [5:0]  note;
        logic [15:0] shifted;
        if (semi >= 6'd60) begin
            oct = 3'd5;
            off = 6'd60;
        end else if (semi >= 6'd48) begin
            oct = 3'd4;
            off = 6'd48;
        end else if (semi >= 6'd36) begin
            oct = 3'd3;
            off = 6'd36;
        end else if (semi >= 6'd24) begin
            oct = 3'd2;
            off = 6'd24;
        end else if (semi >= 6'd12) begin
            oct = 3'd1;
            off = 6'd12;
        end else begin
            oct = 3'd0;
            off = 6'd0;
        end
        note = semi - off;
        shifted = tone_base(note[3:0]) >> ({1'b0, oct} + 4'd3);
        return shifted[12:0];
    endfunction

    // score index, back to zero at or past the score length or the index limit
    function automatic logic [7:0] wrap_idx(input logic [8:0] idx, input logic [8:0] len,
                                            input logic [8:0] limit);
        logic [7:0] res;
        if (idx >= len || idx >= limit) begin
            res = 8'd0;
        end else begin
            res = idx[7:0];
        end
        return res;
    endfunction

endpackage

### rtl/core/note_sequencer_pwm_tone.sv
// note sequencer with pwm tone: beat registers, sequencer state, score memory
// depends on nspt_pkg, nspt_score_mem, assert_macros.svh
// a beat in the input register is moved to the output register when that one is free
// throughput: one beat per cycle while the output is not stalled, set by the single compare and decode pass
// the next score word is prefetched each cycle from the memory's registered read port
// reset clears sequencer state and beat valids but not beat data, registers return to 83 and 1; score memory is kept
`include "assert_macros.svh"

module note_sequencer_pwm_tone
    import nspt_pkg::*;
#(
    parameter int SCORE_DEPTH = SCORE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  nspt_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output nspt_out_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [8:0] IDX_LIMIT = (SCORE_DEPTH < 256) ? 9'(SCORE_DEPTH) : 9'd256;

    logic         in_valid_reg;
    nspt_in_t     in_data_reg;
    logic         out_valid_reg;
    nspt_out_t    out_data_reg;
    nspt_out_t    out_next;

    logic [7:0]   time_unit_reg;
    logic [8:0]   score_length_reg;
    logic [14:0]  tick_reg, tick_next;
    logic [7:0]   note_index_reg, note_index_next;
    logic [6:0]   note_length_reg, note_length_next;
    logic         run_reg, run_next;
    logic [12:0]  period_reg, period_next;
    logic [10:0]  compare_reg, compare_next;
    logic         output_on_reg, output_on_next;
    logic [14:0]  span_reg, span_next;

    logic         out_free;
    logic         move;
    logic         cfg_wr_tu;
    logic         cfg_wr_sl;
    logic [8:0]   score_len_rd;
    logic [7:0]   nxt_index;
    logic [7:0]   rd_index;
    logic [15:0]  score_word;
    logic [12:0]  dec_period;
    logic [15:0]  dec_product;
    logic [14:0]  dec_span;
    logic [14:0]  cfg_span;
    logic         note_over;
    logic         fade;
    logic [17:0]  tick_x5;
    logic [17:0]  span_x3;
    logic [14:0]  remain;
    nspt_mem_wr_t mem_wr;

    assign out_free  = !out_valid_reg || m_ready;
    assign move      = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || move;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    assign cfg_wr_tu = cfg_valid && cfg_index == CFG_TIME_UNIT;
    assign cfg_wr_sl = cfg_valid && cfg_index == CFG_SCORE_LENGTH;

    // word decode from the prefetched next note
    assign dec_period  = period_of(score_word[8:3]);
    assign dec_product = 16'(dec_period) * 16'(score_word[2:0]);
    assign dec_span    = 15'(score_word[15:9]) * 15'(time_unit_reg);
    assign cfg_span    = 15'(note_length_reg) * 15'(cfg_data[7:0]);

    // note end and late-note fade tests
    assign note_over = tick_reg > span_reg;
    assign tick_x5   = {1'b0, tick_reg, 2'b00} + 18'(tick_reg);
    assign span_x3   = {2'b00, span_reg, 1'b0} + 18'(span_reg);
    assign remain    = span_reg - tick_reg;
    assign fade      = (tick_x5 > span_x3) && (remain < 15'd120) && (tick_reg != 15'd63);

    assign nxt_index = wrap_idx(9'(note_index_reg) + 9'd1, score_length_reg, IDX_LIMIT);

    always_comb begin
        tick_next        = tick_reg;
        note_index_next  = note_index_reg;
        note_length_next = note_length_reg;
        run_next         = run_reg;
        period_next      = period_reg;
        compare_next     = compare_reg;
        output_on_next   = output_on_reg;
        span_next        = span_reg;
        mem_wr.en        = 1'b0;
        mem_wr.index     = in_data_reg.load_index;
        mem_wr.word      = in_data_reg.load_word;
        if (move) begin
            unique case (in_data_reg.kind)
                KIND_TICK: begin
                    tick_next = tick_reg + 15'd1;
                end
                KIND_STEP: begin
                    if (run_reg && note_over) begin
                        tick_next        = 15'd0;
                        note_index_next  = nxt_index;
                        note_length_next = score_word[15:9];
                        span_next        = dec_span;
                        if (score_word[2:0] == 3'd0) begin
                            period_next    = 13'd0;
                            compare_next   = 11'd0;
                            output_on_next = 1'b0;
                        end else begin
                            period_next    = dec_period;
                            compare_next   = dec_product[14:4];
                            output_on_next = 1'b1;
                        end
                    end else if (run_reg && fade) begin
                        compare_next = compare_reg >> 2;
                    end
                end
                KIND_PLAY: begin
                    run_next = 1'b1;
                end
                KIND_STOP: begin
                    run_next        = 1'b0;
                    period_next     = 13'd0;
                    compare_next    = 11'd0;
                    output_on_next  = 1'b0;
                    note_index_next = 8'd0;
                end
                KIND_LOAD: begin
                    mem_wr.en = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (cfg_wr_tu) begin
            span_next = cfg_span;
        end
    end

    // prefetch the word after the index this cycle leaves behind
    assign score_len_rd = cfg_wr_sl ? cfg_data : score_length_reg;
    assign rd_index     = wrap_idx(9'(note_index_next) + 9'd1, score_len_rd, IDX_LIMIT);

    nspt_score_mem #(
        .SCORE_DEPTH (SCORE_DEPTH)
    ) u_score_mem (
        .aclk     (aclk),
        .wr       (mem_wr),
        .rd_index (rd_index),
        .rd_word  (score_word)
    );

    always_comb begin
        out_next.pwm_period     = period_next;
        out_next.pwm_compare    = compare_next;
        out_next.pwm_enable     = output_on_next;
        out_next.score_position = note_index_next;
        out_next.playing        = run_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            time_unit_reg    <= TIME_UNIT_RST;
            score_length_reg <= SCORE_LEN_RST;
            tick_reg         <= 15'd0;
            note_index_reg   <= 8'd0;
            note_length_reg  <= 7'd0;
            run_reg          <= 1'b0;
            period_reg       <= 13'd0;
            compare_reg      <= 11'd0;
            output_on_reg    <= 1'b0;
            span_reg         <= 15'd0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_wr_tu) begin
                time_unit_reg <= cfg_data[7:0];
            end
            if (cfg_wr_sl) begin
                score_length_reg <= cfg_data;
            end
            tick_reg        <= tick_next;
            note_index_reg  <= note_index_next;
            note_length_reg <= note_length_next;
            run_reg         <= run_next;
            period_reg      <= period_next;
            compare_reg     <= compare_next;
            output_on_reg   <= output_on_next;
            span_reg        <= span_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (move) begin
            out_data_reg <= out_next;
        end
    end

    `ASSERT_SAME(a_silent_zero, m_valid && !m_data.pwm_enable, (m_data.pwm_period == 13'd0) && (m_data.pwm_compare == 11'd0))
    `ASSERT_NEXT(a_move_fills_out, move, m_valid)
    `ASSERT_SAME(a_pos_in_range, m_valid, 9'(m_data.score_position) < IDX_LIMIT)
    `ASSERT_NEXT(a_stop_clears, move && in_data_reg.kind == KIND_STOP, !run_reg && note_index_reg == 8'd0)

endmodule

### rtl/core/nspt_score_mem.sv
// score memory: one write port, one registered read port with write bypass
// depends on nspt_pkg
module nspt_score_mem
    import nspt_pkg::*;
#(
    parameter int SCORE_DEPTH = SCORE_DEPTH_DEF
) (
    input  logic         aclk,
    input  nspt_mem_wr_t wr,
    input  logic [7:0]   rd_index,
    output logic [15:0]  rd_word
);

    localparam int ADDR_W = $clog2(SCORE_DEPTH);
    localparam int EXT_W  = (ADDR_W > 8) ? ADDR_W : 8;

    logic [15:0]       mem [SCORE_DEPTH];
    logic [15:0]       rd_word_reg;
    logic [ADDR_W-1:0] wr_addr_tab [256];
    logic [ADDR_W-1:0] wr_addr;
    logic [EXT_W-1:0]  rd_ext;
    logic [ADDR_W-1:0] rd_addr;

    // load index folded onto the memory depth
    for (genvar i = 0; i < 256; i++) begin : g_wrap
        assign wr_addr_tab[i] = ADDR_W'(i % SCORE_DEPTH);
    end

    assign wr_addr = wr_addr_tab[wr.index];
    assign rd_ext  = EXT_W'(rd_index);
    assign rd_addr = rd_ext[ADDR_W-1:0];
    assign rd_word = rd_word_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_addr] <= wr.word;
        end
        if (wr.en && wr_addr == rd_addr) begin
            rd_word_reg <= wr.word;
        end else begin
            rd_word_reg <= mem[rd_addr];
        end
    end

endmodule

### tb/sv/note_sequencer_pwm_tone_tb.sv
// self-checking testbench for note_sequencer_pwm_tone: score loads, ticks, steps, play/stop
// depends on nspt_pkg and the note_sequencer_pwm_tone rtl
// a driver, a monitor and an in-bench sequencer predictor compare every result beat
module note_sequencer_pwm_tone_tb;
    import nspt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 2;
    localparam int TAIL_CYCLES   = 4;
    localparam int LONG_HOLDOFF  = 60;
    localparam int MAX_GAP       = 6;

    localparam logic [15:0] PITCH_BASE [12] = '{
        16'd37079, 16'd34998, 16'd33033, 16'd31179, 16'd29429, 16'd27778,
        16'd26219, 16'd24747, 16'd23358, 16'd22047, 16'd20810, 16'd19642
    };

    typedef enum logic [1:0] {
        OP_BEAT,
        OP_DRAIN,
        OP_WRITE
    } op_kind_t;

    typedef struct {
        op_kind_t   what;
        nspt_in_t   beat;
        int         gap;
        nspt_cfg_t  reg_sel;
        logic [8:0] reg_data;
    } note_op_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    nspt_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    nspt_out_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    note_op_t  note_ops[$];
    nspt_out_t tone_expected[$];
    bit        score_loaded [256];
    int        beats_queued = 0;
    int        n_results    = 0;
    int        hold_at      = -1;
    int        errors       = 0;
    bit        tx_steady    = 1'b0;

    logic       in_fire  = 1'b0;
    logic       cfg_fire = 1'b0;
    logic       out_fire = 1'b0;
    int         hold_left = 0;
    bit         gap_done  = 1'b0;
    bit         settled   = 1'b0;
    int         rdy_hold  = 0;

    // predictor state
    logic [7:0]  cur_time_unit;
    logic [8:0]  cur_score_len;
    logic [14:0] tick_cnt;
    logic [7:0]  note_pos;
    logic [6:0]  note_len;
    logic        running;
    logic [12:0] period_now;
    logic [10:0] compare_now;
    logic        tone_on;
    logic [15:0] score_words [256];

    note_sequencer_pwm_tone i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = ~aclk;
    end

    function automatic nspt_out_t sequence_beat(input nspt_in_t b);
        int          span;
        int          nxt;
        logic [15:0] word;
        logic [5:0]  semi;
        logic [2:0]  vol;
        logic [15:0] per_full;
        nspt_out_t   res;
        case (b.kind)
            KIND_TICK: begin
                tick_cnt = tick_cnt + 15'd1;
            end
            KIND_STEP: begin
                if (running) begin
                    span = int'(note_len) * int'(cur_time_unit);
                    if (int'(tick_cnt) > span) begin
                        tick_cnt = '0;
                        nxt = int'(note_pos) + 1;
                        if (nxt >= int'(cur_score_len) || nxt >= 256) begin
                            nxt = 0;
                        end
                        note_pos = 8'(nxt);
                        word = score_words[note_pos];
                        semi = word[8:3];
                        vol = word[2:0];
                        note_len = word[15:9];
                        per_full = PITCH_BASE[semi % 12] >> (semi / 12 + 3);
                        period_now = per_full[12:0];
                        compare_now = 11'((int'(per_full) * int'(vol)) >> 4);
                        if (vol == 3'd0) begin
                            period_now = '0;
                            compare_now = '0;
                            tone_on = 1'b0;
                        end else begin
                            tone_on = 1'b1;
                        end
                    end else if (int'(tick_cnt) > (span * 3) / 5
                                 && span - int'(tick_cnt) < 120) begin
                        if (tick_cnt != 15'd63) begin
                            compare_now = compare_now >> 2;
                        end
                    end
                end
            end
            KIND_PLAY: begin
                running = 1'b1;
            end
            KIND_STOP: begin
                running = 1'b0;
                period_now = '0;
                compare_now = '0;
                tone_on = 1'b0;
                note_pos = '0;
            end
            KIND_LOAD: begin
                score_words[b.load_index] = b.load_word;
            end
            default: begin
            end
        endcase
        res.pwm_period = period_now;
        res.pwm_compare = compare_now;
        res.pwm_enable = tone_on;
        res.score_position = note_pos;
        res.playing = running;
        return res;
    endfunction

    task automatic report_field(input string name, input logic [15:0] exp_v,
                                input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            errors++;
            $display("%0t ns %s mismatch: expected %0d actual %0d", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        in_fire  <= aresetn && s_valid && s_ready;
        cfg_fire <= aresetn && cfg_valid && cfg_ready;
        out_fire <= aresetn && m_valid && m_ready;
        if (!aresetn) begin
            cur_time_unit <= TIME_UNIT_RST;
            cur_score_len <= SCORE_LEN_RST;
            tick_cnt      <= '0;
            note_pos      <= '0;
            note_len      <= '0;
            running       <= 1'b0;
            period_now    <= '0;
            compare_now   <= '0;
            tone_on       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_TIME_UNIT) begin
                    cur_time_unit = cfg_data[7:0];
                end else begin
                    cur_score_len = cfg_data;
                end
            end
            if (m_valid && m_ready) begin
                n_results++;
                if (tone_expected.size() == 0) begin
                    errors++;
                    $display("%0t ns unexpected result beat: expected none actual %h",
                             $time, m_data);
                end else begin
                    report_field("pwm_period", 16'(tone_expected[0].pwm_period),
                                 16'(m_data.pwm_period));
                    report_field("pwm_compare", 16'(tone_expected[0].pwm_compare),
                                 16'(m_data.pwm_compare));
                    report_field("pwm_enable", 16'(tone_expected[0].pwm_enable),
                                 16'(m_data.pwm_enable));
                    report_field("score_position", 16'(tone_expected[0].score_position),
                                 16'(m_data.score_position));
                    report_field("playing", 16'(tone_expected[0].playing),
                                 16'(m_data.playing));
                    void'(tone_expected.pop_front());
                end
            end
            if (s_valid && s_ready) begin
                tone_expected.push_back(sequence_beat(s_data));
            end
        end
    end

    // sender: beats, drain pauses and register writes from the op queue
    always @(negedge aclk) begin : drive_ops
        logic     v;
        logic     cv;
        note_op_t op;
        if (aresetn) begin
            v  = s_valid && !in_fire;
            cv = cfg_valid && !cfg_fire;
            if (!v && !cv) begin
                if (hold_left > 0) begin
                    hold_left--;
                end else if (note_ops.size() > 0) begin
                    op = note_ops[0];
                    if (!gap_done && op.gap > 0) begin
                        hold_left = op.gap - 1;
                        gap_done = 1'b1;
                    end else if (op.what == OP_BEAT) begin
                        v = 1'b1;
                        s_data <= op.beat;
                        gap_done = 1'b0;
                        void'(note_ops.pop_front());
                    end else if (tone_expected.size() == 0) begin
                        if (!settled) begin
                            settled = 1'b1;
                            hold_left = SETTLE_CYCLES;
                        end else begin
                            settled = 1'b0;
                            if (op.what == OP_WRITE) begin
                                cv = 1'b1;
                                cfg_index <= op.reg_sel;
                                cfg_data <= op.reg_data;
                            end
                            void'(note_ops.pop_front());
                        end
                    end
                end
            end
            s_valid <= v;
            cfg_valid <= cv;
        end
    end

    // receiver: random stalls, stall-free stretches, one long hold-off during the burst
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_fire) begin
                if (n_results == hold_at) begin
                    rdy_hold = LONG_HOLDOFF;
                end else if ((n_results / 64) % 4 == 3) begin
                    rdy_hold = 0;
                end else begin
                    rdy_hold = $urandom_range(0, MAX_GAP);
                end
            end
            if (rdy_hold > 0) begin
                rdy_hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_beat(input logic [2:0] kind, input logic [7:0] idx,
                             input logic [15:0] word);
        note_op_t op;
        op.what = OP_BEAT;
        op.beat.kind = kind;
        op.beat.load_index = idx;
        op.beat.load_word = word;
        op.gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        op.reg_sel = CFG_TIME_UNIT;
        op.reg_data = '0;
        note_ops.push_back(op);
        beats_queued++;
    endtask

    task automatic push_noise_beat(input logic [2:0] kind);
        push_beat(kind, 8'($urandom), 16'($urandom));
    endtask

    task automatic push_load(input logic [7:0] idx, input logic [15:0] word);
        score_loaded[idx] = 1'b1;
        push_beat(KIND_LOAD, idx, word);
    endtask

    task automatic push_write(input op_kind_t what, input nspt_cfg_t sel,
                              input logic [8:0] data);
        note_op_t op;
        op.what = what;
        op.beat = '0;
        op.gap = 0;
        op.reg_sel = sel;
        op.reg_data = data;
        note_ops.push_back(op);
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_noise_beat(KIND_TICK);
    endtask

    function automatic logic [15:0] random_word();
        logic [6:0] len;
        len = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 4));
        return {len, 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7))};
    endfunction

    task automatic fill_score(input int count);
        int limit;
        limit = (count < 1) ? 1 : ((count > 256) ? 256 : count);
        for (int i = 0; i < limit; i++) begin
            if (!score_loaded[i]) begin
                push_load(8'(i), random_word());
            end
        end
    endtask

    task automatic note_run(input int blocks);
        int r;
        int k;
        for (int b = 0; b < blocks; b++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                push_ticks($urandom_range(0, 8));
                push_noise_beat(KIND_STEP);
            end else if (r < 80) begin
                push_load(8'($urandom), random_word());
            end else if (r < 85) begin
                push_noise_beat(KIND_PLAY);
            end else if (r < 89) begin
                push_noise_beat(KIND_STOP);
                push_noise_beat(KIND_PLAY);
            end else if (r < 93) begin
                push_noise_beat(3'(int'(KIND_LOAD) + $urandom_range(1, 3)));
            end else begin
                k = $urandom_range(0, 7);
                if (k == int'(KIND_LOAD)) begin
                    push_load(8'($urandom), 16'($urandom));
                end else begin
                    push_noise_beat(3'(k));
                end
            end
        end
    endtask

    initial begin
        // reset settings: unit 83, length 1
        push_noise_beat(KIND_STEP);
        for (int k = int'(KIND_LOAD) + 1; k < 8; k++) begin
            push_noise_beat(3'(k));
        end
        push_load(8'd0, 16'hFFFF);
        push_load(8'd255, 16'h0000);
        push_load(8'd1, {7'd0, 6'd0, 3'd7});
        push_noise_beat(KIND_PLAY);
        push_noise_beat(KIND_TICK);
        push_noise_beat(KIND_STEP);
        push_noise_beat(KIND_STEP);
        push_noise_beat(KIND_STOP);
        push_write(OP_WRITE, CFG_TIME_UNIT, 9'd0);
        push_write(OP_WRITE, CFG_SCORE_LENGTH, 9'd2);
        push_noise_beat(KIND_PLAY);
        repeat (2) begin
            push_noise_beat(KIND_TICK);
            push_noise_beat(KIND_STEP);
        end
        push_load(8'd0, {7'd0, 6'd17, 3'd0});
        repeat (2) begin
            push_noise_beat(KIND_TICK);
            push_noise_beat(KIND_STEP);
        end
        push_noise_beat(KIND_STOP);

        push_write(OP_WRITE, CFG_TIME_UNIT, {1'($urandom), 8'd3});
        push_write(OP_WRITE, CFG_SCORE_LENGTH, 9'd4);
        fill_score(4);
        push_noise_beat(KIND_PLAY);
        note_run(15);
        tx_steady = 1'b1;
        hold_at = beats_queued + 3;
        note_run(10);
        tx_steady = 1'b0;
        push_write(OP_DRAIN, CFG_TIME_UNIT, '0);
        note_run(5);

        // notes spanning 100 ticks, a step lands on tick 63 inside the fade window
        push_write(OP_WRITE, CFG_SCORE_LENGTH, 9'd8);
        for (int i = 0; i < 8; i++) begin
            push_load(8'(i), {7'd10, 6'($urandom_range(0, 63)), 3'($urandom_range(1, 7))});
        end
        push_write(OP_WRITE, CFG_TIME_UNIT, 9'd0);
        push_noise_beat(KIND_PLAY);
        push_noise_beat(KIND_TICK);
        push_noise_beat(KIND_STEP);
        push_write(OP_WRITE, CFG_TIME_UNIT, 9'd10);
        push_ticks(63);
        push_noise_beat(KIND_STEP);
        push_noise_beat(KIND_TICK);
        push_noise_beat(KIND_STEP);
        note_run(12);

        push_write(OP_WRITE, CFG_TIME_UNIT, 9'd0);
        push_write(OP_WRITE, CFG_SCORE_LENGTH, 9'd0);
        push_noise_beat(KIND_PLAY);
        note_run(12);

        push_write(OP_WRITE, CFG_TIME_UNIT, {1'b1, 8'd255});
        push_write(OP_WRITE, CFG_SCORE_LENGTH, 9'd256);
        fill_score(32);
        push_noise_beat(KIND_PLAY);
        note_run(12);

        push_write(OP_WRITE, CFG_TIME_UNIT, 9'd1);
        push_write(OP_WRITE, CFG_SCORE_LENGTH, 9'd511);
        push_noise_beat(KIND_PLAY);
        note_run(12);

        push_write(OP_WRITE, CFG_TIME_UNIT, {1'b0, TIME_UNIT_RST});
        push_write(OP_WRITE, CFG_SCORE_LENGTH, SCORE_LEN_RST);
        push_noise_beat(KIND_PLAY);
        note_run(6);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (note_ops.size() > 0 || s_valid || cfg_valid || tone_expected.size() > 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
